// File: hdl/acs_pkg.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer package
// Shared types, symbol codes and controller command/status structures.
// ----------------------------------------------------------------------------
package acs_pkg;

    // Raw byte codes of the recognized symbols.
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_DASH = 8'h2D;

    // Tally slots, which are also the bit positions of the consensus mask.
    localparam int NUM_SLOTS = 5;
    localparam logic [2:0] SLOT_A    = 3'd0;
    localparam logic [2:0] SLOT_C    = 3'd1;
    localparam logic [2:0] SLOT_G    = 3'd2;
    localparam logic [2:0] SLOT_T    = 3'd3;
    localparam logic [2:0] SLOT_DASH = 3'd4;

    // Fixed field widths.
    localparam int MASK_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int F1_W    = 24;
    localparam int SCORE_W = 40;

    localparam logic [MASK_W-1:0] MASK_EMPTY = MASK_W'(1) << SLOT_DASH;

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_MAX,
        ST_MASK,
        ST_DIV,
        ST_ACC,
        ST_EMIT
    } acs_state_t;

    typedef struct packed {
        logic count;
        logic load_max;
        logic load_mask;
        logic div_step;
        logic acc;
        logic emit;
    } acs_cmd_t;

    typedef struct packed {
        logic size_zero;
        logic div_last;
    } acs_status_t;

    // Tally slot of a raw byte; any unrecognized byte lands on the A slot.
    function automatic logic [2:0] sym_slot(input logic [7:0] b);
        logic [2:0] s;
        unique case (b)
            CH_C:    s = SLOT_C;
            CH_G:    s = SLOT_G;
            CH_T:    s = SLOT_T;
            CH_DASH: s = SLOT_DASH;
            default: s = SLOT_A;
        endcase
        return s;
    endfunction

    function automatic logic sym_is_other(input logic [7:0] b);
        return (b != CH_A) && (b != CH_C) && (b != CH_G) && (b != CH_T) && (b != CH_DASH);
    endfunction

endpackage

// File: hdl/acs_item_if.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer input channel
// Valid/ready channel that carries one alignment symbol per item.
// ----------------------------------------------------------------------------
interface acs_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       column_end;
    logic       alignment_end;

    modport source (output valid, symbol, symbol_valid, column_end, alignment_end,
                    input ready);
    modport sink   (input valid, symbol, symbol_valid, column_end, alignment_end,
                    output ready);
endinterface

// File: hdl/acs_result_if.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer result channel
// Valid/ready channel that carries one column result per item.
// ----------------------------------------------------------------------------
interface acs_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  consensus_mask;
    logic [7:0]  column_size;
    logic [7:0]  column_mismatch;
    logic [39:0] total_score;
    logic        score_valid;

    modport source (output valid, consensus_mask, column_size, column_mismatch,
                    total_score, score_valid, input ready);
    modport sink   (input valid, consensus_mask, column_size, column_mismatch,
                    total_score, score_valid, output ready);
endinterface

// File: hdl/acs_ctrl.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer controller
// Sequences counting, column evaluation, division, accumulation and output.
// ----------------------------------------------------------------------------
module acs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 column_end,
    input  logic                 result_ready,
    input  acs_pkg::acs_status_t status,
    output logic                 item_ready,
    output logic                 result_valid,
    output acs_pkg::acs_cmd_t    cmd
);
    import acs_pkg::*;

    acs_state_t state_reg;
    acs_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       item_fire;

    assign out_free  = !out_valid_reg || result_ready;
    assign item_fire = item_valid && (state_reg == ST_COUNT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COUNT:
            begin
                if (item_fire && column_end)
                    state_next = ST_MAX;
            end
            ST_MAX:  state_next = ST_MASK;
            ST_MASK: state_next = status.size_zero ? ST_ACC : ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_ACC;
            end
            ST_ACC:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_COUNT;
            end
            default: state_next = ST_COUNT;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        item_ready     = 1'b0;
        unique case (state_reg)
            ST_COUNT:
            begin
                item_ready = 1'b1;
                cmd.count  = item_valid;
            end
            ST_MAX:  cmd.load_max  = 1'b1;
            ST_MASK: cmd.load_mask = 1'b1;
            ST_DIV:  cmd.div_step  = 1'b1;
            ST_ACC:  cmd.acc       = 1'b1;
            ST_EMIT: cmd.emit      = out_free;
            default: cmd           = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/acs_datapath.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer datapath
// Tallies, consensus evaluation, restoring divider, score sums, result register.
// ----------------------------------------------------------------------------
module acs_datapath #(
    parameter int MAX_DEPTH = 255,
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  acs_pkg::acs_cmd_t                cmd,
    input  logic [7:0]                       symbol,
    input  logic                             symbol_valid,
    input  logic                             alignment_end,
    output acs_pkg::acs_status_t             status,
    output logic [acs_pkg::MASK_W-1:0]       mask_out,
    output logic [acs_pkg::BYTE_W-1:0]       size_out,
    output logic [acs_pkg::BYTE_W-1:0]       mism_out,
    output logic [acs_pkg::SCORE_W-1:0]      score_out,
    output logic                             final_out
);
    import acs_pkg::*;

    localparam int CW    = $clog2(MAX_DEPTH + 1);
    localparam int F2_W  = FRAC_BITS + 17;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int DCW   = $clog2(FRAC_BITS + 1);
    localparam int SUM_W = F1_W + FRAC_BITS + 1;
    localparam int EXT_W = (SUM_W > SCORE_W) ? SUM_W : SCORE_W + 1;

    localparam logic [CW-1:0]      DEPTH_LIMIT = CW'(MAX_DEPTH);
    localparam logic [DCW-1:0]     DIV_LAST    = DCW'(FRAC_BITS);
    localparam logic [F1_W-1:0]    F1_MAX      = '1;
    localparam logic [F2_W-1:0]    F2_MAX      = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;

    // Column tallies.
    logic [CW-1:0] cnt_reg [NUM_SLOTS];
    logic [CW-1:0] other_reg;
    logic [CW-1:0] size_reg;
    logic          aln_end_reg;

    // Evaluation and divider state.
    logic [CW-1:0]     max_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [CW-1:0]     mism_reg;
    logic [CW:0]       rem_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [DCW-1:0]    dcnt_reg;

    // Alignment sums.
    logic [F1_W-1:0] f1_reg;
    logic [F2_W-1:0] f2_reg;

    logic [2:0]        slot;
    logic              is_other;
    logic              take;
    logic [CW-1:0]     max01;
    logic [CW-1:0]     max23;
    logic [CW-1:0]     max03;
    logic [CW-1:0]     max_next;
    logic [MASK_W-1:0] mask_next;
    logic [CW+2:0]     miss_sum;
    logic [CW-1:0]     mism_next;
    logic [CW:0]       trial;
    logic              ge;
    logic [F1_W:0]     f1_sum;
    logic [F2_W:0]     f2_sum;
    logic [EXT_W-1:0]  score_ext;
    logic [SCORE_W-1:0] score_sat;

    assign slot     = sym_slot(symbol);
    assign is_other = sym_is_other(symbol);
    assign take     = cmd.count && symbol_valid && (size_reg < DEPTH_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                cnt_reg[i] <= '0;
            other_reg   <= '0;
            size_reg    <= '0;
            aln_end_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                cnt_reg[i] <= '0;
            other_reg <= '0;
            size_reg  <= '0;
        end
        else if (cmd.count)
        begin
            aln_end_reg <= alignment_end;
            if (take)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot == 3'(i))
                        cnt_reg[i] <= cnt_reg[i] + CW'(1);
                end
                if (is_other)
                    other_reg <= other_reg + CW'(1);
                size_reg <= size_reg + CW'(1);
            end
        end
    end

    // Column maximum through a small compare tree.
    always_comb
    begin
        max01    = (cnt_reg[0] > cnt_reg[1]) ? cnt_reg[0] : cnt_reg[1];
        max23    = (cnt_reg[2] > cnt_reg[3]) ? cnt_reg[2] : cnt_reg[3];
        max03    = (max01 > max23) ? max01 : max23;
        max_next = (max03 > cnt_reg[4]) ? max03 : cnt_reg[4];
    end

    // Mask of tied maxima; mismatches are the tallies outside the mask plus
    // the unrecognized bytes, which never match even when A is in the mask.
    always_comb
    begin
        miss_sum  = '0;
        mask_next = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cnt_reg[i] == max_reg)
                mask_next[i] = 1'b1;
            else
                miss_sum = miss_sum + (CW+3)'(cnt_reg[i]);
        end
        if (mask_next[SLOT_A])
            miss_sum = miss_sum + (CW+3)'(other_reg);
        mism_next = CW'(miss_sum);
        if (size_reg == '0)
        begin
            mask_next = MASK_EMPTY;
            mism_next = '0;
        end
    end

    // Restoring divider: first step compares the mismatch count itself,
    // the remaining FRAC_BITS steps shift the remainder left.
    assign trial = (dcnt_reg == '0) ? rem_reg : {rem_reg[CW-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, size_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_max)
            max_reg <= max_next;
        if (cmd.load_mask)
        begin
            mask_reg <= mask_next;
            mism_reg <= mism_next;
            rem_reg  <= {1'b0, mism_next};
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? (trial - {1'b0, size_reg}) : trial;
            quo_reg  <= {quo_reg[Q_W-2:0], ge};
            dcnt_reg <= dcnt_reg + DCW'(1);
        end
    end

    assign status.size_zero = (size_reg == '0);
    assign status.div_last  = (dcnt_reg == DIV_LAST);

    assign f1_sum = {1'b0, f1_reg} + (F1_W+1)'(mism_reg);
    assign f2_sum = {1'b0, f2_reg} + (F2_W+1)'(quo_reg);

    // Final score: (F1 scaled to fixed point plus F2) halved, then saturated.
    assign score_ext = ((EXT_W'(f1_reg) << FRAC_BITS) + EXT_W'(f2_reg)) >> 1;
    assign score_sat = (|score_ext[EXT_W-1:SCORE_W]) ? SCORE_MAX : score_ext[SCORE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= '0;
            f2_reg <= '0;
        end
        else if (cmd.acc)
        begin
            f1_reg <= f1_sum[F1_W] ? F1_MAX : f1_sum[F1_W-1:0];
            f2_reg <= f2_sum[F2_W] ? F2_MAX : f2_sum[F2_W-1:0];
        end
        else if (cmd.emit && aln_end_reg)
        begin
            f1_reg <= '0;
            f2_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            mask_out  <= mask_reg;
            size_out  <= BYTE_W'(size_reg);
            mism_out  <= BYTE_W'(mism_reg);
            score_out <= aln_end_reg ? score_sat : '0;
            final_out <= aln_end_reg;
        end
    end

endmodule

// File: hdl/alignment_consensus_scorer_top.sv
// ----------------------------------------------------------------------------
// Alignment consensus scorer top level
// Counts alignment symbols per column and reports consensus and score.
// ----------------------------------------------------------------------------
// Throughput: one symbol item per cycle within a column; the item that closes
// a column is followed by evaluation (maximum, mask, the one-bit-per-cycle
// restoring divider of FRAC_BITS + 1 steps, accumulation, output) before the
// next item is taken. The column result is registered once the evaluation
// ends and the result register is free; an empty column skips the divider.
// Reset (rst_n, asynchronous, active low) clears tallies, sums and the FSM.
// ----------------------------------------------------------------------------
module alignment_consensus_scorer_top #(
    parameter int MAX_DEPTH = 255,
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    acs_item_if.sink      items,
    acs_result_if.source  results
);
    import acs_pkg::*;

    // Commands from the controller and status back from the datapath.
    acs_cmd_t    cmd;
    acs_status_t status;

    logic [MASK_W-1:0]  mask_out;
    logic [BYTE_W-1:0]  size_out;
    logic [BYTE_W-1:0]  mism_out;
    logic [SCORE_W-1:0] score_out;
    logic               final_out;

    // The controller accepts symbol items only while counting. When a column
    // closes it steps through maximum search, mask evaluation, division and
    // accumulation, then loads the result register once it is free.
    acs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (items.valid),
        .column_end   (items.column_end),
        .result_ready (results.ready),
        .status       (status),
        .item_ready   (items.ready),
        .result_valid (results.valid),
        .cmd          (cmd)
    );

    // The datapath holds the tallies, the divider and the alignment sums,
    // and the registered result that stays stable while it waits.
    acs_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .symbol        (items.symbol),
        .symbol_valid  (items.symbol_valid),
        .alignment_end (items.alignment_end),
        .status        (status),
        .mask_out      (mask_out),
        .size_out      (size_out),
        .mism_out      (mism_out),
        .score_out     (score_out),
        .final_out     (final_out)
    );

    assign results.consensus_mask  = mask_out;
    assign results.column_size     = size_out;
    assign results.column_mismatch = mism_out;
    assign results.total_score     = score_out;
    assign results.score_valid     = final_out;

endmodule
